@@ src/smma_pkg.sv @@
// Shared constants, command/status types and address helper for the matrix unit.
`default_nettype none

package smma_pkg;

  localparam int MAX_DIM = 8;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = $clog2(DEPTH);

  localparam int MODE_W  = 2;
  localparam int POS_W   = 3;
  localparam int ELEM_W  = 16;
  localparam int SIZE_W  = 4;
  localparam int RES_W   = 34;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int ACC_W   = RES_W + 1;

  localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MUL    = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic [ADDR_W-1:0] waddr;
    logic              rd;
    logic              first;
    logic              mul;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    logic              emit;
    logic              last;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
  } smma_cmd_t;

  typedef struct packed {
    logic busy;       // terms still in the read/multiply pipe
    logic slot_free;  // output register can take a result this cycle
  } smma_status_t;

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    elem_addr = ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

endpackage

`default_nettype wire

@@ src/smma_in_if.sv @@
// Input channel: load and emit requests.
`default_nettype none

interface smma_in_if;
  logic                                valid;
  logic                                ready;
  logic        [smma_pkg::MODE_W-1:0]  mode;
  logic        [smma_pkg::POS_W-1:0]   row;
  logic        [smma_pkg::POS_W-1:0]   column;
  logic signed [smma_pkg::ELEM_W-1:0]  element;

  modport source (output valid, output mode, output row, output column, output element,
                  input ready);
  modport sink   (input valid, input mode, input row, input column, input element,
                  output ready);
endinterface

`default_nettype wire

@@ src/smma_out_if.sv @@
// Output channel: emitted result elements.
`default_nettype none

interface smma_out_if;
  logic                               valid;
  logic                               ready;
  logic        [smma_pkg::POS_W-1:0]  out_row;
  logic        [smma_pkg::POS_W-1:0]  out_column;
  logic signed [smma_pkg::RES_W-1:0]  result_value;
  logic                               last;

  modport source (output valid, output out_row, output out_column, output result_value,
                  output last, input ready);
  modport sink   (input valid, input out_row, input out_column, input result_value,
                  input last, output ready);
endinterface

`default_nettype wire

@@ src/smma_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none

module smma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/smma_ctrl.sv @@
// Controller: size register, request decode and element/term sequencing.
`default_nettype none

module smma_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write_en,
  input  wire logic [smma_pkg::SIZE_W-1:0]   cfg_write_data,
  smma_in_if.sink                            request,
  input  wire smma_pkg::smma_status_t        status,
  output smma_pkg::smma_cmd_t                cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]                    state, state_next;
  logic [smma_pkg::SIZE_W-1:0]   matrix_size;
  logic                          mul_mode, mul_mode_next;
  logic [smma_pkg::IDX_W-1:0]    i, i_next, j, j_next, k, k_next;
  logic [smma_pkg::IDX_W-1:0]    n_m1;
  logic                          accept, in_range, last_term, last_elem;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= smma_pkg::SIZE_RESET;
    end else if (cfg_write_en) begin
      matrix_size <= cfg_write_data;
    end
  end

  // zero means one, anything past the store size saturates
  always_comb begin
    if (matrix_size == '0) begin
      n_m1 = '0;
    end else if (int'(matrix_size) >= smma_pkg::MAX_DIM) begin
      n_m1 = smma_pkg::IDX_W'(smma_pkg::MAX_DIM - 1);
    end else begin
      n_m1 = smma_pkg::IDX_W'(matrix_size - 1'b1);
    end
  end

  assign request.ready = (state == S_IDLE);
  assign accept        = request.valid && request.ready;
  assign in_range      = (int'(request.row) < smma_pkg::MAX_DIM) &&
                         (int'(request.column) < smma_pkg::MAX_DIM);
  assign last_term     = !mul_mode || (k == n_m1);
  assign last_elem     = (i == n_m1) && (j == n_m1);

  always_comb begin
    state_next    = state;
    mul_mode_next = mul_mode;
    i_next        = i;
    j_next        = j;
    k_next        = k;

    cmd        = '0;
    cmd.waddr  = smma_pkg::elem_addr(request.row[smma_pkg::IDX_W-1:0],
                                     request.column[smma_pkg::IDX_W-1:0]);
    cmd.mul    = mul_mode;
    cmd.first  = (k == '0);
    cmd.a_addr = mul_mode ? smma_pkg::elem_addr(i, k) : smma_pkg::elem_addr(i, j);
    cmd.b_addr = mul_mode ? smma_pkg::elem_addr(k, j) : smma_pkg::elem_addr(i, j);
    cmd.last   = last_elem;
    cmd.row    = i;
    cmd.col    = j;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (request.mode)
            smma_pkg::MODE_LOAD_A: cmd.wr_a = in_range;
            smma_pkg::MODE_LOAD_B: cmd.wr_b = in_range;
            smma_pkg::MODE_ADD, smma_pkg::MODE_MUL: begin
              mul_mode_next = (request.mode == smma_pkg::MODE_MUL);
              i_next        = '0;
              j_next        = '0;
              k_next        = '0;
              state_next    = S_ISSUE;
            end
            default: ;
          endcase
        end
      end
      S_ISSUE: begin
        cmd.rd = 1'b1;
        if (last_term) begin
          k_next     = '0;
          state_next = S_DRAIN;
        end else begin
          k_next = k + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!status.busy && status.slot_free) begin
          cmd.emit = 1'b1;
          if (last_elem) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_ISSUE;
            if (j == n_m1) begin
              j_next = '0;
              i_next = i + 1'b1;
            end else begin
              j_next = j + 1'b1;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mul_mode <= 1'b0;
      i        <= '0;
      j        <= '0;
      k        <= '0;
    end else begin
      state    <= state_next;
      mul_mode <= mul_mode_next;
      i        <= i_next;
      j        <= j_next;
      k        <= k_next;
    end
  end

endmodule

`default_nettype wire

@@ src/smma_dp.sv @@
// Datapath: element stores, multiply/add stage, accumulator and output register.
`default_nettype none

module smma_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic signed [smma_pkg::ELEM_W-1:0]  element,
  input  wire smma_pkg::smma_cmd_t                 cmd,
  output smma_pkg::smma_status_t                   status,
  smma_out_if.source                               response
);

  logic        [smma_pkg::ELEM_W-1:0]  a_raw, b_raw;
  logic signed [smma_pkg::ELEM_W-1:0]  a_val, b_val;
  logic                                rd_valid, rd_first, rd_mul;
  logic                                mul_valid, mul_first;
  logic signed [smma_pkg::PROD_W-1:0]  term;
  logic signed [smma_pkg::ACC_W-1:0]   acc;
  logic signed [smma_pkg::RES_W-1:0]   acc_sat;
  logic                                out_valid;

  smma_ram #(.WIDTH(smma_pkg::ELEM_W), .DEPTH(smma_pkg::DEPTH)) u_store_a (
    .clk   (clk),
    .we    (cmd.wr_a),
    .waddr (cmd.waddr),
    .wdata (element),
    .re    (cmd.rd),
    .raddr (cmd.a_addr),
    .rdata (a_raw)
  );

  smma_ram #(.WIDTH(smma_pkg::ELEM_W), .DEPTH(smma_pkg::DEPTH)) u_store_b (
    .clk   (clk),
    .we    (cmd.wr_b),
    .waddr (cmd.waddr),
    .wdata (element),
    .re    (cmd.rd),
    .raddr (cmd.b_addr),
    .rdata (b_raw)
  );

  assign a_val = signed'(a_raw);
  assign b_val = signed'(b_raw);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      mul_valid <= 1'b0;
    end else begin
      rd_valid  <= cmd.rd;
      mul_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    rd_first  <= cmd.first;
    rd_mul    <= cmd.mul;
    mul_first <= rd_first;
    if (rd_valid) begin
      if (rd_mul) begin
        term <= a_val * b_val;
      end else begin
        term <= smma_pkg::PROD_W'(a_val) + smma_pkg::PROD_W'(b_val);
      end
    end
    if (mul_valid) begin
      acc <= mul_first ? smma_pkg::ACC_W'(term) : acc + smma_pkg::ACC_W'(term);
    end
  end

  // only an all-min-operand dot product leaves the result range (upward)
  always_comb begin
    if (acc[smma_pkg::ACC_W-1] != acc[smma_pkg::ACC_W-2]) begin
      acc_sat = acc[smma_pkg::ACC_W-1] ? {1'b1, {(smma_pkg::RES_W-1){1'b0}}}
                                       : {1'b0, {(smma_pkg::RES_W-1){1'b1}}};
    end else begin
      acc_sat = acc[smma_pkg::RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      response.out_row      <= smma_pkg::POS_W'(cmd.row);
      response.out_column   <= smma_pkg::POS_W'(cmd.col);
      response.result_value <= acc_sat;
      response.last         <= cmd.last;
    end
  end

  assign response.valid   = out_valid;
  assign status.busy      = rd_valid || mul_valid;
  assign status.slot_free = !out_valid || response.ready;

endmodule

`default_nettype wire

@@ src/square_matrix_multiply_add.sv @@
// Top level of the square matrix adder and multiplier.
`default_nettype none

// Loads A and B one element per request (modes 0 and 1) into two 64-entry
// RAMs, one transfer per cycle while idle; an add request (mode 2) then
// streams n*n elements of A+B and a multiply request (mode 3) n*n elements
// of A*B in row-major order, last marking element (n-1,n-1). For each result
// element one term per cycle is read from the single read port of each store,
// then the read/multiply/accumulate pipe drains before the element enters the
// output register; output stalls hold the sequence back. Requests are taken
// only while no add or multiply is in progress; matrix_size (zero acts as 1,
// values above 8 as 8) must be written while the block is idle. Entries read
// before being loaded return arbitrary data.
module square_matrix_multiply_add (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write_en,
  input  wire logic [smma_pkg::SIZE_W-1:0]  cfg_write_data,
  smma_in_if.sink                           request,
  smma_out_if.source                        response
);

  smma_pkg::smma_cmd_t    cmd;
  smma_pkg::smma_status_t status;

  smma_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .request        (request),
    .status         (status),
    .cmd            (cmd)
  );

  smma_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .element  (request.element),
    .cmd      (cmd),
    .status   (status),
    .response (response)
  );

  a_emit_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (status.slot_free && !status.busy))
    else $error("emit while pipe busy or output full");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> response.valid)
    else $error("emitted element not presented");

  a_no_rw_mix: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_a || cmd.wr_b) |-> !cmd.rd)
    else $error("store write during term read");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    request.ready |-> !status.busy)
    else $error("request taken with terms in flight");

endmodule

`default_nettype wire

@@ tb/square_matrix_multiply_add_test.sv @@
// Testbench for the square matrix adder and multiplier: loads, sums, products, sizes.
module square_matrix_multiply_add_test;
  import smma_pkg::*;

  localparam longint SUM_MAX = 64'sd8589934591;
  localparam longint SUM_MIN = -64'sd8589934592;

  typedef struct {
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        column;
    logic signed [RES_W-1:0] value;
    logic                    last;
  } matrix_elem_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_write_en;
  logic [SIZE_W-1:0] cfg_write_data;

  smma_in_if  request_ch ();
  smma_out_if response_ch ();

  square_matrix_multiply_add i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .request        (request_ch),
    .response       (response_ch)
  );

  always #10 clk = ~clk;

  // shadow copy of both stores and the size register
  logic signed [ELEM_W-1:0] held_a [DEPTH];
  logic signed [ELEM_W-1:0] held_b [DEPTH];
  bit                       loaded_a [DEPTH];
  bit                       loaded_b [DEPTH];
  logic [SIZE_W-1:0]        size_shadow;

  matrix_elem_t pending_elems[$];
  int           mismatches;
  int           items_sent;
  bit           tx_idling;
  bit           rx_idling;
  int           stall_left;

  function automatic int active_dim();
    int n;
    n = int'(size_shadow);
    if (n == 0) return 1;
    if (n > MAX_DIM) return MAX_DIM;
    return n;
  endfunction

  // every entry an emit will read has been loaded in both stores
  function automatic bit region_loaded();
    int n;
    n = active_dim();
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (!loaded_a[i*MAX_DIM+j] || !loaded_b[i*MAX_DIM+j]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void predict_request(input logic [MODE_W-1:0] mode,
                                          input logic [POS_W-1:0] row,
                                          input logic [POS_W-1:0] column,
                                          input logic signed [ELEM_W-1:0] element);
    int           n;
    int           addr;
    longint       acc;
    matrix_elem_t elem;
    n = active_dim();
    addr = int'(row) * MAX_DIM + int'(column);
    if (mode == MODE_LOAD_A) begin
      held_a[addr] = element;
      loaded_a[addr] = 1'b1;
    end else if (mode == MODE_LOAD_B) begin
      held_b[addr] = element;
      loaded_b[addr] = 1'b1;
    end else begin
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          acc = 0;
          if (mode == MODE_ADD) begin
            acc = longint'(held_a[i*MAX_DIM+j]) + longint'(held_b[i*MAX_DIM+j]);
          end else begin
            for (int k = 0; k < n; k++)
              acc += longint'(held_a[i*MAX_DIM+k]) * longint'(held_b[k*MAX_DIM+j]);
          end
          // only an all -32768 row/column at size 8 gets here
          if (acc > SUM_MAX) acc = SUM_MAX;
          if (acc < SUM_MIN) acc = SUM_MIN;
          elem.row = POS_W'(i);
          elem.column = POS_W'(j);
          elem.value = RES_W'(acc);
          elem.last = (i == n - 1) && (j == n - 1);
          pending_elems.push_back(elem);
        end
      end
    end
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin
    matrix_elem_t want;
    if (!rst && response_ch.valid && response_ch.ready) begin
      if (pending_elems.size() == 0) begin
        flag_mismatch("unexpected result", longint'(response_ch.result_value), 0);
      end else begin
        want = pending_elems.pop_front();
        if (response_ch.out_row !== want.row)
          flag_mismatch("out_row", longint'(response_ch.out_row), longint'(want.row));
        if (response_ch.out_column !== want.column)
          flag_mismatch("out_column", longint'(response_ch.out_column),
                        longint'(want.column));
        if (response_ch.result_value !== want.value)
          flag_mismatch("result_value", longint'(response_ch.result_value),
                        longint'(want.value));
        if (response_ch.last !== want.last)
          flag_mismatch("last", longint'(response_ch.last), longint'(want.last));
      end
    end
  end

  // result side back-pressure in bursts of random length
  always @(negedge clk) begin
    if (stall_left > 0) begin
      response_ch.ready <= 1'b0;
      stall_left--;
    end else if (rx_idling && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 7);
      response_ch.ready <= 1'b0;
    end else begin
      response_ch.ready <= 1'b1;
    end
  end

  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic [POS_W-1:0] row,
                              input logic [POS_W-1:0] column,
                              input logic signed [ELEM_W-1:0] element);
    int gap;
    gap = (tx_idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      @(negedge clk);
      request_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    request_ch.valid   <= 1'b1;
    request_ch.mode    <= mode;
    request_ch.row     <= row;
    request_ch.column  <= column;
    request_ch.element <= element;
    do @(posedge clk); while (!request_ch.ready);
    predict_request(mode, row, column, element);
    items_sent++;
  endtask

  task automatic send_emit(input logic [MODE_W-1:0] mode);
    send_request(mode, POS_W'($urandom), POS_W'($urandom), ELEM_W'($urandom));
  endtask

  // stop sending and let every expected element come back
  task automatic wait_for_drain();
    @(negedge clk);
    request_ch.valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    // loads leave nothing to wait on, give them time to settle
    repeat (16) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] size_val);
    wait_for_drain();
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= size_val;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    size_shadow = size_val;
  endtask

  function automatic logic signed [ELEM_W-1:0] pick_element();
    case ($urandom_range(0, 7))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return '0;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // size register zero acts as 1, then a plain 1x1
  task automatic test_single_element();
    write_size(4'd0);
    send_request(MODE_LOAD_A, 3'd0, 3'd0, 16'sd32767);
    send_request(MODE_LOAD_B, 3'd0, 3'd0, -16'sd32768);
    send_emit(MODE_ADD);
    send_emit(MODE_MUL);
    write_size(4'd1);
    send_emit(MODE_MUL);
  endtask

  // size above 8 saturates; all -32768 drives every product sum past the top
  task automatic test_saturated_product();
    write_size(4'd15);
    for (int r = 0; r < MAX_DIM; r++) begin
      for (int c = 0; c < MAX_DIM; c++) begin
        send_request(MODE_LOAD_A, POS_W'(r), POS_W'(c), -16'sd32768);
        send_request(MODE_LOAD_B, POS_W'(r), POS_W'(c), -16'sd32768);
      end
    end
    send_emit(MODE_MUL);
    send_emit(MODE_ADD);
  endtask

  // row 0 of A at +max against B at -max: most negative product sum
  task automatic test_extreme_product();
    write_size(4'd8);
    for (int c = 0; c < MAX_DIM; c++)
      send_request(MODE_LOAD_A, 3'd0, POS_W'(c), 16'sd32767);
    send_emit(MODE_MUL);
  endtask

  // loads beyond the active size are kept and show up once the size grows
  task automatic test_load_outside_active();
    write_size(4'd2);
    send_request(MODE_LOAD_A, 3'd6, 3'd5, 16'sd1234);
    send_request(MODE_LOAD_B, 3'd7, 3'd7, -16'sd1);
    send_emit(MODE_ADD);
    write_size(4'd8);
    send_emit(MODE_ADD);
  endtask

  task automatic test_random_sequences();
    int                  first_item;
    int                  n;
    int                  addr;
    logic [SIZE_W-1:0]   size_val;
    logic [MODE_W-1:0]   mode;
    first_item = items_sent;
    while (items_sent - first_item < 24) begin
      if (items_sent - first_item >= 12) begin
        tx_idling = 1'b0;
        rx_idling = 1'b0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: size_val = SIZE_W'($urandom_range(1, 4));
        6, 7:             size_val = SIZE_W'($urandom_range(5, 7));
        8:                size_val = 4'd8;
        default: begin
          size_val = SIZE_W'($urandom_range(8, 15));
          if (size_val == 4'd8) size_val = 4'd0;
        end
      endcase
      write_size(size_val);
      n = active_dim();
      if ($urandom_range(0, 4) == 0) begin
        // noise: any position, any mode (emits only once the active region is loaded)
        repeat ($urandom_range(1, 4)) begin
          mode = MODE_W'($urandom_range(0, 3));
          if (mode >= MODE_ADD && !region_loaded()) mode = MODE_W'($urandom_range(0, 1));
          send_request(mode, POS_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 7)),
                       pick_element());
        end
      end else begin
        // fill the active region (some entries keep old content), then emit
        for (int i = 0; i < n; i++) begin
          for (int j = 0; j < n; j++) begin
            addr = i * MAX_DIM + j;
            if (!loaded_a[addr] || $urandom_range(0, 7) == 0)
              send_request(MODE_LOAD_A, POS_W'(i), POS_W'(j), pick_element());
            if (!loaded_b[addr] || $urandom_range(0, 7) == 0)
              send_request(MODE_LOAD_B, POS_W'(i), POS_W'(j), pick_element());
          end
        end
        repeat ($urandom_range(1, 2))
          send_emit($urandom_range(0, 1) ? MODE_MUL : MODE_ADD);
      end
    end
  endtask

  initial begin
    rst                = 1'b1;
    cfg_write_en       = 1'b0;
    cfg_write_data     = '0;
    request_ch.valid   = 1'b0;
    request_ch.mode    = MODE_LOAD_A;
    request_ch.row     = '0;
    request_ch.column  = '0;
    request_ch.element = '0;
    response_ch.ready  = 1'b0;
    size_shadow        = SIZE_RESET;
    mismatches         = 0;
    items_sent         = 0;
    stall_left         = 0;
    tx_idling          = 1'b1;
    rx_idling          = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_element();
    test_saturated_product();
    test_extreme_product();
    test_load_outside_active();
    test_random_sequences();

    wait_for_drain();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ square_matrix_multiply_add.f @@
src/smma_pkg.sv
src/smma_in_if.sv
src/smma_out_if.sv
src/smma_ram.sv
src/smma_ctrl.sv
src/smma_dp.sv
src/square_matrix_multiply_add.sv
tb/square_matrix_multiply_add_test.sv
